@@ sv/etfp_pkg.sv @@
package etfp_pkg;

  localparam int IMG_WIDTH  = 1024;
  localparam int IMG_HEIGHT = 1024;

  localparam int PIX_W     = 10;
  localparam int ITER_W    = 16;
  localparam int CH_W      = 8;
  localparam int FX_W      = 64;
  localparam int ZOOM_W    = 63;
  localparam int FRAC_W    = 59;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFF_RE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFF_IM   = CFG_IDX_W'(3);

  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(1000);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [ITER_W-1:0] iter_count;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } pix_out_t;

endpackage

@@ sv/escape_time_fractal_pixel.sv @@
// Escape-time fractal pixel engine. One pixel beat in, one beat out with the
// escape count and its gradient color. All 64x64 products (Q4.59) run on one
// shared 32x32 multiplier, four partial products per product, each followed
// by flooring and post-processing. Mapping the pixel to the plane uses two
// products, and each iteration of z = z*z + c uses three products plus the
// bound check; the color step ends the job. The loop ends on the component
// bound, the iteration limit or the |z|^2 test. in_ready is high only while
// the engine is idle, so no new pixel is taken before the result is written;
// a finished result waits in the output register while the next pixel is
// taken, and the color step stalls only while that register is still
// full. Config writes are accepted every cycle but must only happen while
// idle.
module escape_time_fractal_pixel import etfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pix_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pix_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FX_W-1:0]      cfg_data
);

  localparam int DIM_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
  localparam int DW      = ((PIX_W + 1 > $clog2(DIM_MAX + 1)) ? PIX_W + 1
                           : $clog2(DIM_MAX + 1)) + 1;
  localparam int HALF_W  = FX_W / 2;
  localparam int ACC_W   = 2 * FX_W;
  localparam int QC_W    = FX_W + 2;
  localparam int RES_W   = QC_W + 1;
  localparam int SUM_W   = RES_W + 1;

  localparam logic [FX_W-1:0]         TWO_Q  = FX_W'(1) << (FRAC_W + 1);
  localparam logic [FX_W:0]           FOUR_Q = (FX_W + 1)'(1) << (FRAC_W + 2);
  localparam logic signed [SUM_W-1:0] LIM_C  = SUM_W'(1) << (FRAC_W + 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_POST  = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;
  localparam logic [2:0] ST_COLOR = 3'd5;

  localparam logic [2:0] OP_CR = 3'd0;
  localparam logic [2:0] OP_CI = 3'd1;
  localparam logic [2:0] OP_R2 = 3'd2;
  localparam logic [2:0] OP_I2 = 3'd3;
  localparam logic [2:0] OP_T  = 3'd4;

  localparam logic [2:0] MUL_LAST = 3'd4;

  logic [2:0]              state_r;
  logic [2:0]              op_r;
  logic [2:0]              mcnt_r;
  logic [FX_W-1:0]         a_r, b_r;
  logic [FX_W-1:0]         prod_r;
  logic [1:0]              pshift_r;
  logic [ACC_W-1:0]        acc_r;
  logic                    neg_r;
  logic signed [RES_W-1:0] res_r;
  logic signed [DW-1:0]    dy_r;
  logic [FX_W-1:0]         cr_r, ci_r, zr_r, zi_r, mzr_r, mzi_r, r2_r, i2_r;
  logic [ITER_W-1:0]       n_r, max_r;
  logic [ZOOM_W-1:0]       zoom_r;
  logic [FX_W-1:0]         offre_r, offim_r;
  logic                    out_valid_r;
  pix_out_t                out_data_r;

  // pixel to centered half-pixel offset
  logic signed [DW-1:0] dx_c, dy_c;
  logic [DW-1:0]        dx_mag, dy_mag;

  assign dx_c   = $signed(DW'({in_data.pixel_x, 1'b0})) - $signed(DW'(IMG_WIDTH));
  assign dy_c   = $signed(DW'({in_data.pixel_y, 1'b0})) - $signed(DW'(IMG_HEIGHT));
  assign dx_mag = dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
  assign dy_mag = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  // shared multiplier, one 32x32 partial product per cycle
  logic [HALF_W-1:0] a_half, b_half;
  logic [FX_W-1:0]   mul_p;
  logic [1:0]        pshift_c;
  logic [ACC_W-1:0]  acc_add;

  assign a_half   = mcnt_r[1] ? a_r[FX_W-1:HALF_W] : a_r[HALF_W-1:0];
  assign b_half   = mcnt_r[0] ? b_r[FX_W-1:HALF_W] : b_r[HALF_W-1:0];
  assign mul_p    = FX_W'(a_half) * FX_W'(b_half);
  assign pshift_c = {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
  assign acc_add  = ACC_W'(prod_r) << (HALF_W * pshift_r);

  // floor of signed product / 2^sh; negative side uses -(q + rem) = ~q + !rem
  logic [ACC_W-1:0]        q_c;
  logic                    rem_c;
  logic [QC_W-1:0]         qc_c;
  logic signed [RES_W-1:0] fin_res;

  always_comb begin
    unique case (op_r)
      OP_CR, OP_CI: begin
        q_c   = acc_r >> 1;
        rem_c = acc_r[0];
      end
      OP_T: begin
        q_c   = acc_r >> (FRAC_W - 1);
        rem_c = |acc_r[FRAC_W-2:0];
      end
      default: begin
        q_c   = acc_r >> FRAC_W;
        rem_c = |acc_r[FRAC_W-1:0];
      end
    endcase
    qc_c    = (|q_c[ACC_W-1:QC_W]) ? '1 : q_c[QC_W-1:0];
    fin_res = neg_r ? $signed(~{1'b0, qc_c} + RES_W'(!rem_c)) : $signed({1'b0, qc_c});
  end

  // plane coordinate: exact sum with offset, saturated to [-4, 4)
  logic [FX_W-1:0]         off_sel;
  logic signed [SUM_W-1:0] map_sum;
  logic [FX_W-1:0]         map_clamp;
  logic [FX_W:0]           mag_sum;

  assign off_sel = (op_r == OP_CR) ? offre_r : offim_r;
  assign map_sum = SUM_W'(res_r) + SUM_W'($signed(off_sel));
  assign mag_sum = {1'b0, r2_r} + {1'b0, res_r[FX_W-1:0]};

  always_comb begin
    priority if (map_sum >= LIM_C) begin
      map_clamp = FX_W'(LIM_C - SUM_W'(1));
    end else if (map_sum < -LIM_C) begin
      map_clamp = FX_W'(-LIM_C);
    end else begin
      map_clamp = map_sum[FX_W-1:0];
    end
  end

  logic            zr_big, zi_big;
  logic [FX_W-1:0] zr_mag, zi_mag;

  assign zr_big = ($signed(zr_r) > $signed(TWO_Q)) || ($signed(zr_r) < -$signed(TWO_Q));
  assign zi_big = ($signed(zi_r) > $signed(TWO_Q)) || ($signed(zi_r) < -$signed(TWO_Q));
  assign zr_mag = zr_r[FX_W-1] ? -zr_r : zr_r;
  assign zi_mag = zi_r[FX_W-1] ? -zi_r : zi_r;

  // gradient, 8-bit wrap throughout
  logic [CH_W-1:0] u_c, red_c, green_c, blue_c;

  assign u_c = n_r[CH_W-1:0];

  always_comb begin
    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    priority if (n_r == max_r) begin
      red_c = '0;
    end else if (n_r == '0) begin
      red_c = 8'hFF;
    end else if (n_r < ITER_W'(16)) begin
      red_c  = CH_W'((8'd16 - u_c) << 4);
      blue_c = CH_W'((u_c << 4) - 8'd1);
    end else if (u_c < 8'd32) begin
      green_c = CH_W'((u_c - 8'd16) << 4);
      blue_c  = CH_W'(((8'd32 - u_c) << 4) - 8'd1);
    end else if (u_c < 8'd64) begin
      red_c   = CH_W'((u_c - 8'd32) << 3);
      green_c = CH_W'(((8'd64 - u_c) << 3) - 8'd1);
    end else begin
      red_c = CH_W'(8'd255 - ((u_c - 8'd64) << 2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_r       <= MAX_ITER_RST;
      zoom_r      <= '0;
      offre_r     <= '0;
      offim_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_ITER: max_r   <= cfg_data[ITER_W-1:0];
          REG_ZOOM:     zoom_r  <= cfg_data[ZOOM_W-1:0];
          REG_OFF_RE:   offre_r <= cfg_data;
          REG_OFF_IM:   offim_r <= cfg_data;
          default: ;
        endcase
      end

      // the color step reloads the register itself
      if (out_valid_r && out_ready && state_r != ST_COLOR) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dy_r    <= dy_c;
            a_r     <= FX_W'(dx_mag);
            b_r     <= FX_W'(zoom_r);
            neg_r   <= dx_c[DW-1];
            op_r    <= OP_CR;
            mcnt_r  <= '0;
            acc_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mcnt_r != MUL_LAST) begin
            prod_r   <= mul_p;
            pshift_r <= pshift_c;
          end
          if (mcnt_r != '0) begin
            acc_r <= acc_r + acc_add;
          end
          if (mcnt_r == MUL_LAST) begin
            state_r <= ST_FIN;
          end
          mcnt_r <= mcnt_r + 3'd1;
        end
        ST_FIN: begin
          res_r   <= fin_res;
          state_r <= ST_POST;
        end
        ST_POST: begin
          unique case (op_r)
            OP_CR: begin
              cr_r    <= map_clamp;
              a_r     <= FX_W'(dy_mag);
              b_r     <= FX_W'(zoom_r);
              neg_r   <= dy_r[DW-1];
              op_r    <= OP_CI;
              mcnt_r  <= '0;
              acc_r   <= '0;
              state_r <= ST_MUL;
            end
            OP_CI: begin
              ci_r    <= map_clamp;
              zr_r    <= cr_r;
              zi_r    <= map_clamp;
              n_r     <= '0;
              state_r <= ST_CHK;
            end
            OP_R2: begin
              r2_r    <= res_r[FX_W-1:0];
              a_r     <= mzi_r;
              b_r     <= mzi_r;
              neg_r   <= 1'b0;
              op_r    <= OP_I2;
              mcnt_r  <= '0;
              acc_r   <= '0;
              state_r <= ST_MUL;
            end
            OP_I2: begin
              i2_r <= res_r[FX_W-1:0];
              if (mag_sum > FOUR_Q) begin
                state_r <= ST_COLOR;
              end else begin
                a_r     <= mzr_r;
                b_r     <= mzi_r;
                neg_r   <= zr_r[FX_W-1] ^ zi_r[FX_W-1];
                op_r    <= OP_T;
                mcnt_r  <= '0;
                acc_r   <= '0;
                state_r <= ST_MUL;
              end
            end
            OP_T: begin
              zi_r    <= res_r[FX_W-1:0] + ci_r;
              zr_r    <= r2_r - i2_r + cr_r;
              n_r     <= n_r + ITER_W'(1);
              state_r <= ST_CHK;
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_CHK: begin
          if (n_r >= max_r || zr_big || zi_big) begin
            state_r <= ST_COLOR;
          end else begin
            mzr_r   <= zr_mag;
            mzi_r   <= zi_mag;
            a_r     <= zr_mag;
            b_r     <= zr_mag;
            neg_r   <= 1'b0;
            op_r    <= OP_R2;
            mcnt_r  <= '0;
            acc_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_COLOR: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r           <= 1'b1;
            out_data_r.iter_count <= n_r;
            out_data_r.red        <= red_c;
            out_data_r.green      <= green_c;
            out_data_r.blue       <= blue_c;
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/etfp_checker.sv @@
module etfp_checker import etfp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pix_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second pixel taken while one is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after pixel beat");

  a_zero_count_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.iter_count == '0 && out_data.red != '0 |->
      out_data.red == 8'hFF && out_data.green == '0 && out_data.blue == '0)
    else $error("bad colour for zero count");

  a_green_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.green != '0 |-> out_data.red == '0 || out_data.blue == '0)
    else $error("green band mixes red and blue");

endmodule

bind escape_time_fractal_pixel etfp_checker u_etfp_checker (.*);
